>>> hw/rtl/clcd_pkg.sv
// ============================================================================
// clcd_pkg
// Shared types, command codes and helpers for the character LCD sequencer.
// ============================================================================
package clcd_pkg;

   // Default display geometry
   localparam int unsigned DEF_COLUMNS = 16;
   localparam int unsigned DEF_ROWS    = 2;

   // Operation codes
   localparam logic [2:0] OP_PRINT  = 3'd0;
   localparam logic [2:0] OP_SET    = 3'd1;
   localparam logic [2:0] OP_CLEAR  = 3'd2;
   localparam logic [2:0] OP_HOME   = 3'd3;
   localparam logic [2:0] OP_GLYPH  = 3'd4;

   // Control characters
   localparam logic [7:0] CHAR_TAB      = 8'd9;
   localparam logic [7:0] CHAR_NEWLINE  = 8'd10;
   localparam logic [7:0] CHAR_RETURN   = 8'd13;

   // Controller commands
   localparam logic [7:0] CMD_CLEAR     = 8'h01;
   localparam logic [7:0] CMD_HOME      = 8'h02;
   localparam logic [7:0] CMD_SET_CGRAM = 8'h40;
   localparam logic [7:0] CMD_SET_DDRAM = 8'h80;

   // Register select codes
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   // DDRAM base address of lines 1 to 4 (entry 0 is line 1)
   localparam logic [3:0][6:0] LINE_BASE = {7'h54, 7'h14, 7'h40, 7'h00};

   // Byte counts of one job
   localparam int unsigned      COUNT_W     = 4;
   localparam logic [COUNT_W-1:0] COUNT_NONE  = 4'd0;
   localparam logic [COUNT_W-1:0] COUNT_ONE   = 4'd1;
   localparam logic [COUNT_W-1:0] COUNT_TWO   = 4'd2;
   localparam logic [COUNT_W-1:0] COUNT_GLYPH = 4'd10;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  char_code;
      logic [2:0]  target_line;
      logic [4:0]  target_column;
      logic [3:0]  glyph_slot;
      logic [63:0] glyph_rows;
   } req_word_type;

   typedef struct packed {
      logic       register_select;
      logic [7:0] lcd_byte;
      logic       last;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] line;
      logic [4:0] column;
   } cursor_type;

   // Byte list of one item: head byte, optional glyph rows, trailing address
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic               head_rs;
      logic [7:0]         head_byte;
      logic [63:0]        rows;
      logic [7:0]         tail_byte;
   } job_type;

   // Set DDRAM address command for a 1-based line and column
   function automatic logic [7:0] ddram_cmd(input logic [2:0] line, input logic [4:0] col);
      logic [2:0] line_idx;
      logic [6:0] addr;
      line_idx = line - 3'd1;
      addr     = LINE_BASE[line_idx[1:0]] + {2'b00, col} - 7'd1;
      return CMD_SET_DDRAM | {1'b0, addr};
   endfunction

endpackage

>>> hw/rtl/clcd_decode.sv
// ============================================================================
// clcd_decode
// Decodes one text operation into its byte list and the next cursor position.
// ============================================================================
module clcd_decode #(
   parameter int unsigned COLUMNS = clcd_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = clcd_pkg::DEF_ROWS
) (
   input  clcd_pkg::req_word_type req,
   input  clcd_pkg::cursor_type   cursor,
   output clcd_pkg::job_type      job,
   output clcd_pkg::cursor_type   cursor_next
);
   import clcd_pkg::*;

   localparam logic [5:0] COLS_V = 6'(COLUMNS);
   localparam logic [2:0] ROWS_V = 3'(ROWS);

   logic [2:0] line_inc;
   logic [2:0] wrap_line;
   logic [5:0] col_inc;
   logic [5:0] tab_col;

   assign line_inc  = cursor.line + 3'd1;
   assign wrap_line = (line_inc > ROWS_V) ? 3'd1 : line_inc;
   assign col_inc   = {1'b0, cursor.column} + 6'd1;
   assign tab_col   = cursor.column[0] ? col_inc : ({1'b0, cursor.column} + 6'd2);

   always_comb begin
      job           = '0;
      job.rows      = req.glyph_rows;
      job.tail_byte = ddram_cmd(cursor.line, cursor.column);
      cursor_next   = cursor;
      unique case (req.op)
         OP_PRINT: begin
            priority if (req.char_code == CHAR_NEWLINE) begin
               if (cursor.line < ROWS_V) begin
                  job.count          = COUNT_ONE;
                  job.head_byte      = ddram_cmd(line_inc, 5'd1);
                  cursor_next.line   = line_inc;
                  cursor_next.column = 5'd1;
               end
            end else if (req.char_code == CHAR_TAB) begin
               if (tab_col < COLS_V) begin
                  job.count          = COUNT_ONE;
                  job.head_byte      = ddram_cmd(cursor.line, tab_col[4:0]);
                  cursor_next.column = tab_col[4:0];
               end
            end else if (req.char_code == CHAR_RETURN) begin
               job.count          = COUNT_ONE;
               job.head_byte      = ddram_cmd(cursor.line, 5'd1);
               cursor_next.column = 5'd1;
            end else begin
               job.head_rs   = RS_DATA;
               job.head_byte = req.char_code;
               if (col_inc > COLS_V) begin
                  // wrap to column 1 of the next line (line 1 after the last row), then re-address
                  job.count          = COUNT_TWO;
                  job.tail_byte      = ddram_cmd(wrap_line, 5'd1);
                  cursor_next.line   = wrap_line;
                  cursor_next.column = 5'd1;
               end else begin
                  job.count          = COUNT_ONE;
                  cursor_next.column = col_inc[4:0];
               end
            end
         end
         OP_SET: begin
            if (req.target_line >= 3'd1 && req.target_line <= ROWS_V &&
                req.target_column >= 5'd1 && {1'b0, req.target_column} <= COLS_V) begin
               job.count   = COUNT_ONE;
               job.head_byte = ddram_cmd(req.target_line, req.target_column);
               cursor_next.line   = req.target_line;
               cursor_next.column = req.target_column;
            end
         end
         OP_CLEAR, OP_HOME: begin
            job.count          = COUNT_ONE;
            job.head_byte      = (req.op == OP_CLEAR) ? CMD_CLEAR : CMD_HOME;
            cursor_next.line   = 3'd1;
            cursor_next.column = 5'd1;
         end
         OP_GLYPH: begin
            if (!req.glyph_slot[3]) begin
               job.count     = COUNT_GLYPH;
               job.head_byte = CMD_SET_CGRAM | {2'b00, req.glyph_slot[2:0], 3'b000};
            end
         end
         default: begin
            job.count = COUNT_NONE;
         end
      endcase
   end

endmodule

>>> hw/rtl/char_lcd_cursor_sequencer_top.sv
// ============================================================================
// char_lcd_cursor_sequencer_top
// Text operations in, character LCD command and data bytes out.
// ============================================================================
// Usage:
//   req_* channel takes one text operation per word (print, set cursor,
//   clear, home, load glyph). rsp_* channel gives one controller byte per
//   word, tagged command or data, with last set on the final byte of an item.
//   The first byte of an item goes through the job register, then the output
//   register, before it is on rsp.
//   Items of zero or one byte are taken at one item per cycle while rsp_stall
//   is low; a wrapping print gives two bytes and a glyph load ten. The byte
//   sequencer emits one byte a cycle from the job register while rsp_stall is
//   low; req_stall stays high until the last byte of the job leaves.
//   Items that cause no bytes are accepted and dropped.
//   Reset puts the cursor at line 1, column 1 and empties the job and output
//   registers. While rsp_stall is high with rsp_valid set, the output word
//   and the job register hold, so req stalls too once a job is waiting.
// ============================================================================
module char_lcd_cursor_sequencer_top #(
   parameter int unsigned COLUMNS = clcd_pkg::DEF_COLUMNS,
   parameter int unsigned ROWS    = clcd_pkg::DEF_ROWS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  clcd_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output clcd_pkg::rsp_word_type rsp_data
);
   import clcd_pkg::*;

   // decoder outputs
   job_type      dec_job;
   cursor_type   dec_cursor;

   // job register and sequencer
   job_type            job_ff,       job_in;
   logic               job_valid_ff, job_valid_in;
   logic [COUNT_W-1:0] idx_ff,       idx_in;
   cursor_type         cursor_ff,    cursor_in;

   // output register
   rsp_word_type out_ff,       out_in;
   logic         out_valid_ff, out_valid_in;

   logic               out_free;
   logic               emit;
   logic               emit_last;
   logic               req_take;
   logic [COUNT_W-1:0] last_idx;
   logic [COUNT_W-1:0] row_idx;
   rsp_word_type       sel_word;

   clcd_decode #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_decode (
      .req         (req_data),
      .cursor      (cursor_ff),
      .job         (dec_job),
      .cursor_next (dec_cursor)
   );

   // Output register frees when empty or being taken this cycle
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign emit      = job_valid_ff && out_free;
   assign last_idx  = job_ff.count - COUNT_ONE;
   assign emit_last = emit && (idx_ff == last_idx);

   // Accept a new item only when the job register is empty or empties this cycle
   assign req_stall = job_valid_ff && !emit_last;
   assign req_take  = req_valid && !req_stall;

   // Pick the byte at the sequencer index: head, glyph rows, then address
   assign row_idx = idx_ff - COUNT_ONE;
   always_comb begin
      sel_word.last = (idx_ff == last_idx);
      if (idx_ff == COUNT_NONE) begin
         sel_word.register_select = job_ff.head_rs;
         sel_word.lcd_byte        = job_ff.head_byte;
      end else if (idx_ff == last_idx) begin
         sel_word.register_select = RS_COMMAND;
         sel_word.lcd_byte        = job_ff.tail_byte;
      end else begin
         sel_word.register_select = RS_DATA;
         sel_word.lcd_byte        = job_ff.rows[{row_idx[2:0], 3'b000} +: 8];
      end
   end

   always_comb begin
      job_in       = job_ff;
      job_valid_in = job_valid_ff;
      idx_in       = idx_ff;
      cursor_in    = cursor_ff;
      if (req_take) begin
         // load the next job; drop items that cause no bytes
         job_in       = dec_job;
         job_valid_in = (dec_job.count != COUNT_NONE);
         idx_in       = COUNT_NONE;
         cursor_in    = dec_cursor;
      end else if (emit_last) begin
         job_valid_in = 1'b0;
      end else if (emit) begin
         idx_in = idx_ff + COUNT_ONE;
      end

      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         out_in       = sel_word;
         out_valid_in = 1'b1;
      end else if (out_free) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         job_valid_ff     <= 1'b0;
         idx_ff           <= COUNT_NONE;
         cursor_ff.line   <= 3'd1;
         cursor_ff.column <= 5'd1;
         out_valid_ff     <= 1'b0;
      end else begin
         job_valid_ff <= job_valid_in;
         idx_ff       <= idx_in;
         cursor_ff    <= cursor_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

`ifndef SYNTHESIS
   // Sequencer index stays inside the job's byte list
   assert property (@(posedge clock) disable iff (reset)
      job_valid_ff |-> (idx_ff < job_ff.count))
      else $error("byte index ran past job length");

   // Cursor always holds a legal display position
   assert property (@(posedge clock) disable iff (reset)
      (cursor_ff.line >= 3'd1) && (cursor_ff.line <= 3'(ROWS)) &&
      (cursor_ff.column >= 5'd1) && ({1'b0, cursor_ff.column} <= 6'(COLUMNS)))
      else $error("cursor left the display");

   // A new item enters a busy job register only as its last byte leaves
   assert property (@(posedge clock) disable iff (reset)
      (req_take && job_valid_ff) |-> emit_last)
      else $error("job overwritten before it drained");

   // Index advances by exactly one byte per emitted word within a job
   assert property (@(posedge clock) disable iff (reset)
      (emit && !emit_last) |=> (idx_ff == $past(idx_ff) + COUNT_ONE))
      else $error("byte index skipped");

   // Output register is empty right after reset
   assert property (@(posedge clock)
      reset |=> !out_valid_ff)
      else $error("output valid after reset");
`endif

endmodule
